>>> rtl/core/bcc_pkg.sv
package bcc_pkg;

  // field and state widths
  localparam int unsigned CyclesW   = 8;
  localparam int unsigned StatusW   = 16;
  localparam int unsigned ElapsedW  = 27;
  localparam int unsigned LimitW    = 26;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // status word bits that end discharge and charge in normal mode
  localparam int unsigned BitDischarged = 5;
  localparam int unsigned BitCharged    = 4;

  localparam logic [LimitW-1:0]   MsPerSec   = LimitW'(1000);
  localparam logic [LimitW-1:0]   MsPerMin   = LimitW'(60000);
  localparam logic [ElapsedW-1:0] ElapsedMax = '1;

  // request function codes
  localparam logic FuncTick      = 1'b0;
  localparam logic FuncStartStop = 1'b1;

  typedef enum logic [2:0] {
    PhIdle      = 3'd0,
    PhDischarge = 3'd1,
    PhPauseDis  = 3'd2,
    PhCharge    = 3'd3,
    PhPauseChg  = 3'd4
  } phase_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgDemoMode    = 3'd0,
    CfgDemoDisSec  = 3'd1,
    CfgDemoChgSec  = 3'd2,
    CfgPauseDisMin = 3'd3,
    CfgPauseChgMin = 3'd4
  } cfg_idx_e;

  // controller state
  typedef struct packed {
    phase_e                phase;
    logic                  running;
    logic [CyclesW-1:0]    cycles;
    logic [ElapsedW-1:0]   elapsed;
    logic                  relay_dis;
    logic                  relay_chg;
  } ctl_state_t;

  // phase limits, already scaled to milliseconds
  typedef struct packed {
    logic                demo_mode;
    logic [LimitW-1:0]   demo_dis_ms;
    logic [LimitW-1:0]   demo_chg_ms;
    logic [LimitW-1:0]   pause_dis_ms;
    logic [LimitW-1:0]   pause_chg_ms;
  } limits_t;

endpackage

>>> rtl/core/bcc_step.sv
module bcc_step (
  input  bcc_pkg::ctl_state_t               cur_i,
  input  bcc_pkg::limits_t                  lim_i,
  input  logic                              func_i,
  input  logic [bcc_pkg::CyclesW-1:0]       cycle_count_i,
  input  logic [bcc_pkg::StatusW-1:0]       battery_status_i,
  output bcc_pkg::ctl_state_t               nxt_o
);

  logic [bcc_pkg::ElapsedW-1:0] elapsed_inc;
  logic [bcc_pkg::LimitW-1:0]   limit;
  logic                         timed_out;
  logic [bcc_pkg::CyclesW-1:0]  cycles_dec;

  // saturating millisecond count
  assign elapsed_inc = (cur_i.elapsed == bcc_pkg::ElapsedMax) ? cur_i.elapsed
                     : cur_i.elapsed + 1'b1;
  assign cycles_dec  = cur_i.cycles - 1'b1;

  // one limit per phase
  always_comb begin
    case (cur_i.phase)
      bcc_pkg::PhDischarge: limit = lim_i.demo_dis_ms;
      bcc_pkg::PhPauseDis:  limit = lim_i.demo_mode ? lim_i.demo_dis_ms : lim_i.pause_dis_ms;
      bcc_pkg::PhCharge:    limit = lim_i.demo_chg_ms;
      bcc_pkg::PhPauseChg:  limit = lim_i.demo_mode ? lim_i.demo_chg_ms : lim_i.pause_chg_ms;
      default:              limit = '0;
    endcase
  end

  assign timed_out = elapsed_inc > bcc_pkg::ElapsedW'(limit);

  always_comb begin
    nxt_o = cur_i;
    if (func_i == bcc_pkg::FuncStartStop) begin
      if (!cur_i.running && (cycle_count_i != '0)) begin
        nxt_o.running = 1'b1;
        nxt_o.cycles  = cycle_count_i;
        nxt_o.phase   = bcc_pkg::PhDischarge;
        nxt_o.elapsed = '0;
      end else begin
        nxt_o.running   = 1'b0;
        nxt_o.phase     = bcc_pkg::PhIdle;
        nxt_o.relay_dis = 1'b0;
        nxt_o.relay_chg = 1'b0;
      end
    end else begin
      nxt_o.elapsed = elapsed_inc;
      if (cur_i.running) begin
        unique case (cur_i.phase)
          bcc_pkg::PhDischarge: begin
            nxt_o.relay_dis = 1'b1;
            nxt_o.relay_chg = 1'b0;
            if (lim_i.demo_mode ? timed_out : battery_status_i[bcc_pkg::BitDischarged]) begin
              nxt_o.phase   = bcc_pkg::PhPauseDis;
              nxt_o.elapsed = '0;
            end
          end
          bcc_pkg::PhPauseDis: begin
            nxt_o.relay_dis = 1'b0;
            nxt_o.relay_chg = 1'b0;
            if (timed_out) begin
              nxt_o.phase   = bcc_pkg::PhCharge;
              nxt_o.elapsed = '0;
            end
          end
          bcc_pkg::PhCharge: begin
            nxt_o.relay_dis = 1'b0;
            nxt_o.relay_chg = 1'b1;
            if (lim_i.demo_mode ? timed_out : battery_status_i[bcc_pkg::BitCharged]) begin
              nxt_o.phase   = bcc_pkg::PhPauseChg;
              nxt_o.elapsed = '0;
            end
          end
          bcc_pkg::PhPauseChg: begin
            nxt_o.relay_dis = 1'b0;
            nxt_o.relay_chg = 1'b0;
            if (timed_out) begin
              nxt_o.cycles = cycles_dec;
              if (cycles_dec != '0) begin
                nxt_o.phase   = bcc_pkg::PhDischarge;
                nxt_o.elapsed = '0;
              end else begin
                nxt_o.running = 1'b0;
                nxt_o.phase   = bcc_pkg::PhIdle;
              end
            end
          end
          default: begin
            nxt_o.relay_dis = 1'b0;
            nxt_o.relay_chg = 1'b0;
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/core/battery_cycle_controller_core.sv
// Battery conditioning sequencer: each request is either a one millisecond
// tick (func 0) or a start/stop press (func 1), and every request produces
// exactly one result with the phase, running flag, remaining cycles and both
// relay drive levels after it. The block takes one request per clock: the
// controller state is updated in the accept cycle and the result lands in an
// output register, so a new request is taken whenever that register is empty
// or being drained in the same cycle. The result turns valid in the cycle
// after accept. Configuration writes are taken at any time (cfg_ready_o is
// always high); second and minute values are scaled to milliseconds as they
// are written, so phase limits are ready on the very next cycle. Writes to
// indexes outside the register list are accepted and ignored.
module battery_cycle_controller_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bcc_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [bcc_pkg::CfgDataW-1:0]      cfg_data_i,

  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [bcc_pkg::CyclesW-1:0]       cycle_count_i,
  input  logic [bcc_pkg::StatusW-1:0]       battery_status_i,

  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        phase_o,
  output logic                              running_o,
  output logic [bcc_pkg::CyclesW-1:0]       cycles_left_o,
  output logic                              relay_discharge_o,
  output logic                              relay_charge_o
);

  bcc_pkg::limits_t    lim_q;
  bcc_pkg::ctl_state_t ctl_q, ctl_d;
  logic                out_valid_q;
  logic [2:0]          phase_q;
  logic                running_q;
  logic [bcc_pkg::CyclesW-1:0] cycles_q;
  logic                relay_dis_q;
  logic                relay_chg_q;
  logic                in_fire;
  logic                cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  // output register empty or draining this cycle
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  // configuration registers, stored in milliseconds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        bcc_pkg::CfgDemoMode: begin
          lim_q.demo_mode <= cfg_data_i[0];
        end
        bcc_pkg::CfgDemoDisSec: begin
          lim_q.demo_dis_ms <= bcc_pkg::LimitW'(cfg_data_i) * bcc_pkg::MsPerSec;
        end
        bcc_pkg::CfgDemoChgSec: begin
          lim_q.demo_chg_ms <= bcc_pkg::LimitW'(cfg_data_i) * bcc_pkg::MsPerSec;
        end
        bcc_pkg::CfgPauseDisMin: begin
          lim_q.pause_dis_ms <= bcc_pkg::LimitW'(cfg_data_i[9:0]) * bcc_pkg::MsPerMin;
        end
        bcc_pkg::CfgPauseChgMin: begin
          lim_q.pause_chg_ms <= bcc_pkg::LimitW'(cfg_data_i[9:0]) * bcc_pkg::MsPerMin;
        end
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // next-state logic for one request
  bcc_step u_step (
    .cur_i            (ctl_q),
    .lim_i            (lim_q),
    .func_i           (func_i),
    .cycle_count_i    (cycle_count_i),
    .battery_status_i (battery_status_i),
    .nxt_o            (ctl_d)
  );

  // controller state advances only on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.phase     <= bcc_pkg::PhIdle;
      ctl_q.running   <= 1'b0;
      ctl_q.cycles    <= '0;
      ctl_q.elapsed   <= '0;
      ctl_q.relay_dis <= 1'b0;
      ctl_q.relay_chg <= 1'b0;
    end else if (in_fire) begin
      ctl_q <= ctl_d;
    end
  end

  // result register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, snapshot of the state after the request
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      phase_q     <= ctl_d.phase;
      running_q   <= ctl_d.running;
      cycles_q    <= ctl_d.cycles;
      relay_dis_q <= ctl_d.relay_dis;
      relay_chg_q <= ctl_d.relay_chg;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign phase_o           = phase_q;
  assign running_o         = running_q;
  assign cycles_left_o     = cycles_q;
  assign relay_discharge_o = relay_dis_q;
  assign relay_charge_o    = relay_chg_q;

endmodule

>>> dv/battery_cycle_controller_core_test.sv
`timescale 1ns / 1ps

module battery_cycle_controller_core_test;
  import bcc_pkg::*;

  // time scaling and status bits as the controller is specified
  localparam int unsigned MsInSecond    = 1000;
  localparam int unsigned MsInMinute    = 60000;
  localparam int unsigned DischargedBit = 5;
  localparam int unsigned ChargedBit    = 4;
  localparam int unsigned MinutesW      = 10;

  // extra wait after the last result before touching registers
  localparam int unsigned SettleCycles = 4;
  localparam longint unsigned CycleLimit = 64'd6_000_000;
  localparam int unsigned RandomItems = 336;
  localparam int unsigned RandomSettings = 6;
  // ticks spent inside a long pause before stopping it
  localparam int unsigned HoldTicks = 40;

  localparam logic [StatusW-1:0] StNone       = '0;
  localparam logic [StatusW-1:0] StAll        = '1;
  localparam logic [StatusW-1:0] StDischarged = StatusW'(1) << DischargedBit;
  localparam logic [StatusW-1:0] StCharged    = StatusW'(1) << ChargedBit;

  typedef struct packed {
    logic [2:0]         phase;
    logic               running;
    logic [CyclesW-1:0] cycles_left;
    logic               relay_dis;
    logic               relay_chg;
  } ctl_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 func_i;
  logic [CyclesW-1:0]   cycle_count_i;
  logic [StatusW-1:0]   battery_status_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [2:0]           phase_o;
  logic                 running_o;
  logic [CyclesW-1:0]   cycles_left_o;
  logic                 relay_discharge_o;
  logic                 relay_charge_o;

  battery_cycle_controller_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .cycle_count_i     (cycle_count_i),
    .battery_status_i  (battery_status_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .phase_o           (phase_o),
    .running_o         (running_o),
    .cycles_left_o     (cycles_left_o),
    .relay_discharge_o (relay_discharge_o),
    .relay_charge_o    (relay_charge_o)
  );

  // controller state as predicted by the testbench
  phase_e             ctl_phase     = PhIdle;
  logic               ctl_running   = 1'b0;
  logic [CyclesW-1:0] ctl_cycles    = '0;
  logic [ElapsedW-1:0] ctl_elapsed  = '0;
  logic               ctl_relay_dis = 1'b0;
  logic               ctl_relay_chg = 1'b0;

  // register settings as last written
  logic                set_demo          = 1'b0;
  logic [CfgDataW-1:0] set_dis_sec       = '0;
  logic [CfgDataW-1:0] set_chg_sec       = '0;
  logic [MinutesW-1:0] set_pause_dis_min = '0;
  logic [MinutesW-1:0] set_pause_chg_min = '0;

  ctl_result_t     pending_results[$];
  int unsigned     mismatches = 0;
  longint unsigned clock_count = 0;
  // set for the last stretch of the run: no idling on either side
  logic            steady_tail = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    clock_count <= clock_count + 1;
    if (clock_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // pause limits in ms; demo pauses reuse the demo phase lengths
  function automatic logic [31:0] pause_limit_ms(input logic after_discharge);
    if (set_demo)
      return 32'(after_discharge ? set_dis_sec : set_chg_sec) * MsInSecond;
    return 32'(after_discharge ? set_pause_dis_min : set_pause_chg_min) * MsInMinute;
  endfunction

  // update the predicted controller for one request, return what it shows after
  function automatic ctl_result_t advance_controller(input logic fn,
                                                     input logic [CyclesW-1:0] cnt,
                                                     input logic [StatusW-1:0] st);
    ctl_result_t r;
    logic        done;
    if (fn == FuncStartStop) begin
      ctl_running = ~ctl_running;
      if (ctl_running && cnt != '0) begin
        ctl_cycles  = cnt;
        ctl_phase   = PhDischarge;
        ctl_elapsed = '0;
      end else begin
        // stop, or start with zero cycles: idle with the count left alone
        ctl_running   = 1'b0;
        ctl_phase     = PhIdle;
        ctl_relay_dis = 1'b0;
        ctl_relay_chg = 1'b0;
      end
    end else begin
      // elapsed counter saturates and runs even while idle
      if (ctl_elapsed != '1) ctl_elapsed = ctl_elapsed + 1'b1;
      if (ctl_running) begin
        case (ctl_phase)
          PhDischarge: begin
            // relay stays driven on the tick that leaves the phase
            ctl_relay_dis = 1'b1;
            ctl_relay_chg = 1'b0;
            done = set_demo ? (32'(ctl_elapsed) > 32'(set_dis_sec) * MsInSecond)
                            : st[DischargedBit];
            if (done) begin
              ctl_phase   = PhPauseDis;
              ctl_elapsed = '0;
            end
          end
          PhPauseDis: begin
            ctl_relay_dis = 1'b0;
            ctl_relay_chg = 1'b0;
            if (32'(ctl_elapsed) > pause_limit_ms(1'b1)) begin
              ctl_phase   = PhCharge;
              ctl_elapsed = '0;
            end
          end
          PhCharge: begin
            ctl_relay_dis = 1'b0;
            ctl_relay_chg = 1'b1;
            done = set_demo ? (32'(ctl_elapsed) > 32'(set_chg_sec) * MsInSecond)
                            : st[ChargedBit];
            if (done) begin
              ctl_phase   = PhPauseChg;
              ctl_elapsed = '0;
            end
          end
          PhPauseChg: begin
            ctl_relay_dis = 1'b0;
            ctl_relay_chg = 1'b0;
            if (32'(ctl_elapsed) > pause_limit_ms(1'b0)) begin
              // one full cycle done
              ctl_cycles = ctl_cycles - 1'b1;
              if (ctl_cycles != '0) begin
                ctl_phase   = PhDischarge;
                ctl_elapsed = '0;
              end else begin
                // last cycle: back to idle, elapsed keeps counting
                ctl_running = 1'b0;
                ctl_phase   = PhIdle;
              end
            end
          end
          default: begin
            ctl_relay_dis = 1'b0;
            ctl_relay_chg = 1'b0;
          end
        endcase
      end
    end
    r.phase       = ctl_phase;
    r.running     = ctl_running;
    r.cycles_left = ctl_cycles;
    r.relay_dis   = ctl_relay_dis;
    r.relay_chg   = ctl_relay_chg;
    return r;
  endfunction

  // result side: compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    ctl_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (phase_o !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, phase_o);
          mismatches++;
        end
        if (running_o !== want.running) begin
          $error("running: expected %0d, got %0d", want.running, running_o);
          mismatches++;
        end
        if (cycles_left_o !== want.cycles_left) begin
          $error("cycles_left: expected %0d, got %0d", want.cycles_left, cycles_left_o);
          mismatches++;
        end
        if (relay_discharge_o !== want.relay_dis) begin
          $error("relay_discharge: expected %0d, got %0d", want.relay_dis,
                 relay_discharge_o);
          mismatches++;
        end
        if (relay_charge_o !== want.relay_chg) begin
          $error("relay_charge: expected %0d, got %0d", want.relay_chg, relay_charge_o);
          mismatches++;
        end
      end
    end
  end

  // result side back-pressure: open stretches with random stall bursts
  initial begin : result_sink
    int open_len;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      open_len = $urandom_range(1, 24);
      repeat (open_len) @(posedge clk_i);
      if (!steady_tail && $urandom_range(0, 1) == 1) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  end

  // one request; valid stays up after acceptance unless a gap follows
  task automatic send_request(input logic fn, input logic [CyclesW-1:0] cnt,
                              input logic [StatusW-1:0] st);
    int gap;
    if (!steady_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= fn;
    cycle_count_i    <= cnt;
    battery_status_i <= st;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(advance_controller(fn, cnt, st));
  endtask

  // the field a request does not use gets random content
  task automatic send_press(input logic [CyclesW-1:0] cnt);
    send_request(FuncStartStop, cnt, StatusW'($urandom));
  endtask

  task automatic send_tick(input logic [StatusW-1:0] st);
    send_request(FuncTick, CyclesW'($urandom), st);
  endtask

  // mostly clean status words where the end bits show up now and then
  function automatic logic [StatusW-1:0] random_status();
    logic [StatusW-1:0] s;
    s = StatusW'($urandom);
    if ($urandom_range(0, 9) != 0) begin
      s[DischargedBit] = ($urandom_range(0, 5) == 0);
      s[ChargedBit]    = ($urandom_range(0, 5) == 0);
    end
    return s;
  endfunction

  // short runs mostly, with zero, full and arbitrary counts mixed in
  function automatic logic [CyclesW-1:0] random_cycles();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return CyclesW'($urandom_range(1, 3));
    if (pick == 7) return '0;
    if (pick == 8) return '1;
    return CyclesW'($urandom);
  endfunction

  // drop valid and let every pending result come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write request; valid is lowered by the caller after the last one
  task automatic write_reg(input logic [CfgIndexW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgDemoMode:    set_demo          = data[0];
      CfgDemoDisSec:  set_dis_sec       = data;
      CfgDemoChgSec:  set_chg_sec       = data;
      CfgPauseDisMin: set_pause_dis_min = data[MinutesW-1:0];
      CfgPauseChgMin: set_pause_chg_min = data[MinutesW-1:0];
      default: ;
    endcase
  endtask

  // all five registers, junk in the unused upper bits, then writes to
  // indexes past the list which must change nothing
  task automatic load_settings(input logic demo,
                               input logic [CfgDataW-1:0] dis_sec,
                               input logic [CfgDataW-1:0] chg_sec,
                               input logic [MinutesW-1:0] pause_dis,
                               input logic [MinutesW-1:0] pause_chg);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    write_reg(CfgDemoMode, {junk[CfgDataW-1:1], demo});
    write_reg(CfgDemoDisSec, dis_sec);
    write_reg(CfgDemoChgSec, chg_sec);
    junk = CfgDataW'($urandom);
    write_reg(CfgPauseDisMin, {junk[CfgDataW-1:MinutesW], pause_dis});
    junk = CfgDataW'($urandom);
    write_reg(CfgPauseChgMin, {junk[CfgDataW-1:MinutesW], pause_chg});
    for (int i = int'(CfgPauseChgMin) + 1; i < (1 << CfgIndexW); i++)
      if ($urandom_range(0, 1) == 1) write_reg(CfgIndexW'(i), CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // walk the sequencer by hand through every phase and press case
  task automatic test_directed();
    // idle tick, and start presses with zero cycles force idle
    send_tick(StAll);
    send_press('0);
    send_press('0);
    // two full discharge and charge rounds in status bit mode with zero pauses
    send_press(CyclesW'(2));
    send_tick(StNone);
    send_tick(StCharged);
    send_tick(StDischarged);
    send_tick(StNone);
    send_tick(StDischarged);
    send_tick(StCharged);
    send_tick(StNone);
    send_tick(StAll);
    send_tick(StAll);
    send_tick(StAll);
    send_tick(StAll);
    send_tick(StAll);
    // full count, then a stop, a restart and another stop; stops keep the count
    send_press('1);
    send_tick(StAll & ~StDischarged);
    send_press('0);
    send_press('1);
    send_press('1);
    // demo mode with zero lengths: each phase ends on its first tick
    wait_for_results();
    load_settings(1'b1, '0, '0, MinutesW'($urandom), MinutesW'($urandom));
    send_press(CyclesW'(1));
    send_tick(StNone);
    send_tick(StAll);
    send_tick(StNone);
    send_tick(StAll);
  endtask

  // one second demo discharge checked to the exact tick, then a stretch of
  // the pause that follows it before a stop press
  task automatic test_demo_timeouts();
    wait_for_results();
    load_settings(1'b1, CfgDataW'(1), CfgDataW'(2), MinutesW'($urandom),
                  MinutesW'($urandom));
    if (ctl_running) send_press(random_cycles());
    send_press(CyclesW'(1));
    while (ctl_phase == PhDischarge) send_tick(random_status());
    repeat (HoldTicks) send_tick(random_status());
    send_press(random_cycles());
  endtask

  // one minute rest after discharge in status bit mode holds across ticks
  task automatic test_minute_pause();
    wait_for_results();
    load_settings(1'b0, CfgDataW'($urandom), CfgDataW'($urandom), MinutesW'(1), '0);
    if (ctl_running) send_press(random_cycles());
    send_press(CyclesW'(1));
    while (ctl_phase == PhDischarge) send_tick(random_status());
    repeat (HoldTicks) send_tick(random_status());
    send_press(random_cycles());
  endtask

  // random traffic under several register settings, extremes among them
  task automatic test_random_traffic();
    int per_setting;
    per_setting = RandomItems / RandomSettings;
    for (int k = 0; k < RandomSettings; k++) begin
      wait_for_results();
      case (k)
        0: load_settings(1'b0, CfgDataW'($urandom), CfgDataW'($urandom), '0, '0);
        1: load_settings(1'b1, '0, '0, MinutesW'($urandom), MinutesW'($urandom));
        2: load_settings(1'b0, '0, '0, '1, '0);
        3: load_settings(1'b1, '0, '1, '0, '0);
        4: load_settings(1'b0, '1, '1, '0, '1);
        default: load_settings(1'b1, '0, '0, '1, '1);
      endcase
      // last setting runs without any idling
      if (k == RandomSettings - 1) steady_tail = 1'b1;
      for (int n = 0; n < per_setting; n++) begin
        // hold the sender once until everything has come back
        if (k == 0 && n == per_setting / 2) wait_for_results();
        if (!ctl_running) begin
          if ($urandom_range(0, 2) == 0) send_press(random_cycles());
          else send_tick(random_status());
        end else if ($urandom_range(0, 39) == 0) begin
          send_press(CyclesW'($urandom));
        end else begin
          send_tick(random_status());
        end
      end
    end
  endtask

  initial begin : run
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    func_i           = FuncTick;
    cycle_count_i    = '0;
    battery_status_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_demo_timeouts();
    test_minute_pause();
    test_random_traffic();
    wait_for_results();

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> battery_cycle_controller_core.f
rtl/core/bcc_pkg.sv
rtl/core/bcc_step.sv
rtl/core/battery_cycle_controller_core.sv
dv/battery_cycle_controller_core_test.sv
